FILE: sv/bws_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_pkg
// Shared types and constants of the box window statistics unit.
// ----------------------------------------------------------------------------
package bws_pkg;

    localparam int unsigned IMAGE_WIDTH  = 4096;
    localparam int unsigned IMAGE_HEIGHT = 4096;

    localparam logic [23:0] SD_MAX = 24'hFFFFFF;
    localparam logic [19:0] CENT_TOP_X =
        ((IMAGE_WIDTH - 1) * 256 > 1048575) ? 20'hFFFFF : 20'((IMAGE_WIDTH - 1) * 256);
    localparam logic [19:0] CENT_TOP_Y =
        ((IMAGE_HEIGHT - 1) * 256 > 1048575) ? 20'hFFFFF : 20'((IMAGE_HEIGHT - 1) * 256);

    localparam logic [1:0] CFG_X_START = 2'd0;
    localparam logic [1:0] CFG_Y_START = 2'd1;
    localparam logic [1:0] CFG_X_END   = 2'd2;
    localparam logic [1:0] CFG_Y_END   = 2'd3;

    // accumulated frame state handed from the front to the back
    typedef struct packed {
        logic [24:0]        count;
        logic signed [39:0] sum;
        logic [54:0]        sumsq;
        logic signed [51:0] xw;
        logic signed [51:0] yw;
        logic signed [15:0] min_v;
        logic [23:0]        min_pos;
        logic signed [15:0] max_v;
        logic [23:0]        max_pos;
    } t_snap;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic               push;
    } t_q_status;

    typedef struct packed {
        logic [19:0]        cy;
        logic [19:0]        cx;
        logic [11:0]        max_y;
        logic [11:0]        max_x;
        logic signed [15:0] max_v;
        logic [11:0]        min_y;
        logic [11:0]        min_x;
        logic signed [15:0] min_v;
        logic [23:0]        sd;
        logic signed [23:0] mean;
        logic signed [39:0] sum;
        logic [24:0]        count;
    } t_result;

endpackage

FILE: sv/bws_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_front
// Box test and per-pixel accumulation; hands a frame snapshot on last pixel.
// ----------------------------------------------------------------------------
module bws_front import bws_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic signed [15:0] i_value,
    input  logic [11:0]        i_x,
    input  logic [11:0]        i_y,
    input  logic               i_valid_px,
    input  logic               i_last,
    input  logic [11:0]        i_x_start,
    input  logic [11:0]        i_y_start,
    input  logic [12:0]        i_x_end,
    input  logic [12:0]        i_y_end,
    output logic               o_push,
    output t_snap              o_snap
);

    t_snap r_acc;
    t_snap n_acc;

    logic               in_box;
    logic signed [31:0] sq;
    logic signed [28:0] xv;
    logic signed [28:0] yv;

    assign sq = i_value * i_value;
    assign xv = $signed({1'b0, i_x}) * i_value;
    assign yv = $signed({1'b0, i_y}) * i_value;

    assign in_box = i_valid_px
                 && i_x >= i_x_start && {1'b0, i_x} < i_x_end
                 && i_y >= i_y_start && {1'b0, i_y} < i_y_end
                 && 32'(i_x) < IMAGE_WIDTH && 32'(i_y) < IMAGE_HEIGHT
                 && !r_acc.count[24];

    always_comb begin
        n_acc = r_acc;
        if (in_box) begin
            if (r_acc.count == '0 || i_value < r_acc.min_v) begin
                n_acc.min_v   = i_value;
                n_acc.min_pos = {i_y, i_x};
            end
            if (r_acc.count == '0 || i_value > r_acc.max_v) begin
                n_acc.max_v   = i_value;
                n_acc.max_pos = {i_y, i_x};
            end
            n_acc.sum   = r_acc.sum + 40'(i_value);
            n_acc.sumsq = r_acc.sumsq + {23'b0, sq[31:0]};
            n_acc.xw    = r_acc.xw + 52'(xv);
            n_acc.yw    = r_acc.yw + 52'(yv);
            n_acc.count = r_acc.count + 25'd1;
        end
    end

    assign o_push = i_accept && i_last;
    assign o_snap = n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_accept) begin
            // clear after the last pixel of the frame
            r_acc <= i_last ? '0 : n_acc;
        end
    end

endmodule

FILE: sv/bws_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_queue
// Two-entry snapshot queue between the accumulator and the finisher.
// ----------------------------------------------------------------------------
module bws_queue import bws_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_snap     i_snap,
    input  logic      i_pop,
    output t_snap     o_head,
    output t_q_status o_status
);

    t_snap      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_head          = r_mem[r_rp];
    assign o_status.full   = r_cnt == 2'd2;
    assign o_status.empty  = r_cnt == 2'd0;
    assign o_status.push   = i_push;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

FILE: sv/bws_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bws_back
// Frame finisher: shift-add multiplier, restoring divider and bitwise root.
// ----------------------------------------------------------------------------
module bws_back import bws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_empty,
    input  t_snap   i_head,
    output logic    o_pop,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_VAR1, S_VAR2, S_SQRT, S_MEAN, S_CX, S_CY, S_DONE
    } t_state;

    t_state      r_state;
    t_snap       r_snap;
    logic [6:0]  r_cnt;
    logic [79:0] r_ma;
    logic [39:0] r_mb;
    logic [79:0] r_acc;
    logic [79:0] r_t1;
    logic [95:0] r_dvd;
    logic [39:0] r_dvs;
    logic [39:0] r_rem;
    logic [63:0] r_sv;
    logic [63:0] r_sres;
    logic [63:0] r_sbit;
    logic        r_sat;
    logic [23:0] r_sd;
    logic [23:0] r_mean;
    logic [19:0] r_cx;
    t_result     r_res;
    logic        r_valid;

    logic [79:0] n_acc;
    logic [40:0] dtry;
    logic [40:0] dsub;
    logic        dge;
    logic [39:0] n_rem;
    logic [95:0] n_dvd;
    logic [63:0] ssum;
    logic        sge;
    logic [63:0] n_sv;
    logic [63:0] n_sres;
    logic [39:0] sum_mag;
    logic [51:0] xw_mag;
    logic [51:0] yw_mag;
    logic [79:0] var_d;
    logic [23:0] sd_fin;
    logic [19:0] cent;
    logic        cent_neg;
    logic [19:0] cent_top;

    assign sum_mag = r_snap.sum[39] ? 40'(-r_snap.sum) : 40'(r_snap.sum);
    assign xw_mag  = r_snap.xw[51] ? 52'(-r_snap.xw) : 52'(r_snap.xw);
    assign yw_mag  = r_snap.yw[51] ? 52'(-r_snap.yw) : 52'(r_snap.yw);

    assign n_acc = r_mb[0] ? r_acc + r_ma : r_acc;
    assign var_d = (r_t1 >= n_acc) ? r_t1 - n_acc : '0;

    assign dtry  = {r_rem, r_dvd[95]};
    assign dsub  = dtry - {1'b0, r_dvs};
    assign dge   = dtry >= {1'b0, r_dvs};
    assign n_rem = dge ? dsub[39:0] : dtry[39:0];
    assign n_dvd = {r_dvd[94:0], dge};

    assign ssum   = r_sres + r_sbit;
    assign sge    = r_sv >= ssum;
    assign n_sv   = sge ? r_sv - ssum : r_sv;
    assign n_sres = sge ? (r_sres >> 1) + r_sbit : r_sres >> 1;
    assign sd_fin = (r_sat || n_sres > 64'(SD_MAX)) ? SD_MAX : n_sres[23:0];

    // centroid clamp from the divider result of the current pass
    always_comb begin
        cent_top = (r_state == S_CY) ? CENT_TOP_Y : CENT_TOP_X;
        cent_neg = (r_state == S_CY) ? (r_snap.yw[51] != r_snap.sum[39])
                                     : (r_snap.xw[51] != r_snap.sum[39]);
        if (r_snap.sum == '0 || cent_neg) begin
            cent = '0;
        end else if (n_dvd > 96'(cent_top)) begin
            cent = cent_top;
        end else begin
            cent = n_dvd[19:0];
        end
    end

    assign o_pop   = (r_state == S_IDLE) && !i_q_empty;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_snap  <= i_head;
                        r_ma    <= {25'b0, i_head.sumsq};
                        r_mb    <= {15'b0, i_head.count};
                        r_acc   <= '0;
                        r_cnt   <= 7'd39;
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_t1    <= n_acc;
                        r_ma    <= {40'b0, sum_mag};
                        r_mb    <= sum_mag;
                        r_acc   <= '0;
                        r_cnt   <= 7'd39;
                        r_state <= S_MUL2;
                    end
                end
                S_MUL2: begin
                    r_acc <= n_acc;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_dvd   <= {var_d, 16'b0};
                        r_dvs   <= {15'b0, r_snap.count};
                        r_rem   <= '0;
                        r_cnt   <= 7'd95;
                        r_state <= S_VAR1;
                    end
                end
                S_VAR1: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_rem   <= '0;
                        r_cnt   <= 7'd95;
                        r_state <= S_VAR2;
                    end
                end
                S_VAR2: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_sat   <= |n_dvd[95:64];
                        r_sv    <= n_dvd[63:0];
                        r_sres  <= '0;
                        r_sbit  <= 64'h4000_0000_0000_0000;
                        r_cnt   <= 7'd31;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    r_sv   <= n_sv;
                    r_sres <= n_sres;
                    r_sbit <= r_sbit >> 2;
                    r_cnt  <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_sd    <= sd_fin;
                        // round half away: add half the divisor before dividing
                        r_dvd   <= 96'({sum_mag, 8'b0}) + 96'(r_snap.count >> 1);
                        r_rem   <= '0;
                        r_cnt   <= 7'd95;
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_mean  <= r_snap.sum[39] ? 24'(-n_dvd[23:0]) : n_dvd[23:0];
                        r_dvd   <= 96'({xw_mag, 8'b0}) + 96'(sum_mag >> 1);
                        r_dvs   <= sum_mag;
                        r_rem   <= '0;
                        r_cnt   <= 7'd95;
                        r_state <= S_CX;
                    end
                end
                S_CX: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        r_cx    <= cent;
                        r_dvd   <= 96'({yw_mag, 8'b0}) + 96'(sum_mag >> 1);
                        r_rem   <= '0;
                        r_cnt   <= 7'd95;
                        r_state <= S_CY;
                    end
                end
                S_CY: begin
                    r_dvd <= n_dvd;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt - 7'd1;
                    if (r_cnt == '0) begin
                        if (r_snap.count == '0) begin
                            r_res <= '0;
                        end else begin
                            r_res.count <= r_snap.count;
                            r_res.sum   <= r_snap.sum;
                            r_res.mean  <= r_mean;
                            r_res.sd    <= r_sd;
                            r_res.min_v <= r_snap.min_v;
                            r_res.min_x <= r_snap.min_pos[11:0];
                            r_res.min_y <= r_snap.min_pos[23:12];
                            r_res.max_v <= r_snap.max_v;
                            r_res.max_x <= r_snap.max_pos[11:0];
                            r_res.max_y <= r_snap.max_pos[23:12];
                            r_res.cx    <= r_cx;
                            r_res.cy    <= cent;
                        end
                        r_valid <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: sv/box_window_statistics_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_window_statistics_unit
// Region statistics over a raster pixel stream inside a configurable box.
// ----------------------------------------------------------------------------
// Pixels are taken one per clock and accumulated at once; the last pixel of a
// frame pushes a snapshot of the sums into a two-entry queue and the
// accumulators restart, so the next frame streams in without a gap. A finisher
// works on one snapshot at a time with a shift-add multiplier, a restoring
// divider and a bitwise square root: 80 multiply steps, five 96-step divisions
// and 32 root steps for each frame from queue to result. The pixel side stalls
// only when two finished frames are still waiting.
module box_window_statistics_unit import bws_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [1:0]   i_cfg_index,
    input  logic [12:0]  i_cfg_data,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // pixel_value[15:0], pixel_x[27:16], pixel_y[39:28]
    input  logic [39:0]  i_s_axis_tdata,
    // pixel_valid[0]
    input  logic         i_s_axis_tuser,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // point_count[24:0], total_sum[64:25], mean_value[88:65],
    // std_deviation[112:89], min_value[128:113], min_x[140:129],
    // min_y[152:141], max_value[168:153], max_x[180:169], max_y[192:181],
    // centroid_x[212:193], centroid_y[232:213], zero[239:233]
    output logic [239:0] o_m_axis_tdata
);

    logic [11:0] r_x_start;
    logic [11:0] r_y_start;
    logic [12:0] r_x_end;
    logic [12:0] r_y_end;

    logic      accept;
    logic      push;
    logic      pop;
    t_snap     snap;
    t_snap     head;
    t_q_status q_st;
    t_result   res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_start <= '0;
            r_y_start <= '0;
            r_x_end   <= 13'd4096;
            r_y_end   <= 13'd4096;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_X_START: r_x_start <= i_cfg_data[11:0];
                CFG_Y_START: r_y_start <= i_cfg_data[11:0];
                CFG_X_END:   r_x_end   <= i_cfg_data;
                CFG_Y_END:   r_y_end   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    assign o_s_axis_tready = !q_st.full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    bws_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_value    ($signed(i_s_axis_tdata[15:0])),
        .i_x        (i_s_axis_tdata[27:16]),
        .i_y        (i_s_axis_tdata[39:28]),
        .i_valid_px (i_s_axis_tuser),
        .i_last     (i_s_axis_tlast),
        .i_x_start  (r_x_start),
        .i_y_start  (r_y_start),
        .i_x_end    (r_x_end),
        .i_y_end    (r_y_end),
        .o_push     (push),
        .o_snap     (snap)
    );

    bws_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_snap   (snap),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_st)
    );

    bws_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_st.empty),
        .i_head    (head),
        .o_pop     (pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_res     (res)
    );

    assign o_m_axis_tdata = {7'b0, res};

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_st.push |-> !q_st.full || pop)
        else $error("snapshot pushed into a full queue");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.count == '0 |-> res.sum == '0 && res.cx == '0 && res.sd == '0)
        else $error("empty window with nonzero fields");

    a_min_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && res.count != '0 |-> res.min_v <= res.max_v)
        else $error("minimum above maximum");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_st.empty && !o_m_axis_tvalid)
        else $error("pop from empty queue or while a result waits");

endmodule
